/* rtl/core/bfr1d_pkg.sv */
// package for the limited cubic face reconstruction block
// holds the sequencer states, register indexes, fixed widths and the divide-by-three digit step
// no dependencies
package bfr1d_pkg;

    localparam int OUT_WIDTH       = 32;
    localparam int IN_WIDTH        = 32;
    localparam int LIMIT_WIDTH     = 4;
    localparam int TOL_WIDTH       = 16;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int CFG_INDEX_WIDTH = 1;
    localparam int FILL_WIDTH      = 3;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ITER_LIMIT = 1'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TOLERANCE  = 1'd1;

    localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 4'd6;
    localparam logic [TOL_WIDTH-1:0]   TOL_RESET   = 16'd1;
    localparam logic [FILL_WIDTH-1:0]  FILL_FULL   = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_SHIFT,
        S_CLAMP,
        S_EVAL,
        S_MOVE,
        S_DONE
    } bfr_state_t;

    // one radix-16 digit of an unsigned divide by three
    // returns {quotient nibble, new remainder}
    function automatic logic [5:0] div3_digit(input logic [1:0] rem, input logic [3:0] nib);
        logic [2:0] t;
        logic [1:0] r;
        logic [3:0] q;
        r = rem;
        q = '0;
        for (int i = 3; i >= 0; i--)
        begin
            t = {r, nib[i]};
            if (t >= 3'd3)
            begin
                t    = t - 3'd3;
                q[i] = 1'b1;
            end
            r = t[1:0];
        end
        return {q, r};
    endfunction

endpackage

/* rtl/core/bds_face_reconstruct_1d.sv */
// Limited cubic (BDS style) face reconstruction along one grid line, top level
// uses bfr1d_pkg for states, register indexes and the divide-by-three digit step
//
// Cells stream in one word at a time; a word with line_start set begins a new line. From the
// fifth cell of a line on, each cell e yields one word with the left and right faces of the
// cell two places back. One shared divide-by-three unit, four quotient bits per cycle, forms
// both cubic estimates in turn; then the mean shift, the clamp and the limiter follow; the
// limiter runs at most iteration_limit passes, each pass a move state and an eval state. The
// divide works on DIGITS = ceil((VALUE_WIDTH+5)/4) digits (10 at the default width). A cell
// that yields a word also stays busy while the word before still waits in the output
// register. A cell that yields nothing is stored without leaving the idle state. A finished
// word waits in the output register while the next cell is taken in.
module bds_face_reconstruct_1d
    import bfr1d_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [IN_WIDTH-1:0] cell_value,
    input  logic                       line_start,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [OUT_WIDTH-1:0] left_face,
    output logic signed [OUT_WIDTH-1:0] right_face
);

    localparam int VW     = VALUE_WIDTH;
    localparam int IW     = (VW < IN_WIDTH) ? VW : IN_WIDTH;
    localparam int NW     = VW + 5;
    localparam int MW     = 4 * ((VW + 8) / 4);
    localparam int DIGITS = MW / 4;
    localparam int DCW    = $clog2(DIGITS);
    localparam int FW     = VW + 4;
    localparam int LW     = ((FW > TOL_WIDTH + 1) ? FW : TOL_WIDTH + 1) + 2;
    localparam int OW     = (VW > OUT_WIDTH) ? VW : OUT_WIDTH;
    localparam logic [DCW-1:0] DCNT_LAST = DCW'(DIGITS - 1);

    // control state
    bfr_state_t              state_reg, state_next;
    logic [FILL_WIDTH-1:0]   fill_reg;
    logic [LIMIT_WIDTH-1:0]  lim_reg;
    logic [TOL_WIDTH-1:0]    tol_reg;
    logic [DCW-1:0]          dcnt_reg;
    logic [LIMIT_WIDTH-1:0]  pass_reg;
    logic                    sel_reg;
    logic                    out_valid_reg;

    // payload
    logic signed [VW-1:0]    win_reg [4];
    logic signed [VW-1:0]    a_reg;
    logic [MW-1:0]           mag_reg;
    logic [1:0]              rem_reg;
    logic                    neg_reg;
    logic signed [FW-1:0]    lf_reg, rf_reg;
    logic                    up_reg, cl_reg, cr_reg;
    logic signed [LW-1:0]    corr_reg;
    logic signed [OUT_WIDTH-1:0] left_out_reg, right_out_reg;

    logic                    accept;
    logic                    load_out;
    logic [FILL_WIDTH-1:0]   fill_eff;
    logic signed [VW-1:0]    e_val;

    logic signed [VW-1:0]    op_o, op_p, op_q, op_r;
    logic signed [NW-1:0]    sum_pq, sum_or, num, n4, mag_in;
    logic [5:0]              digit;
    logic [MW-1:0]           mag_nx;
    logic signed [MW:0]      quot_s;
    logic signed [FW-1:0]    quot_f;

    logic signed [FW-1:0]    s_f, b_f, d_f;
    logic signed [FW:0]      face_sum;
    logic signed [FW:0]      shift_v;
    logic signed [FW-1:0]    lo_l, hi_l, lo_r, hi_r;

    logic signed [LW-1:0]    l_w, r_w, s_w, tol_w;
    logic signed [LW-1:0]    diff, abs_diff, dl, dr, adl, adr, step_l, step_r;
    logic                    up, cl, cr;

    assign accept   = in_valid && in_ready;
    assign fill_eff = line_start ? '0 : fill_reg;
    assign e_val    = VW'($signed(cell_value[IW-1:0]));

    // cubic operands: left uses a,b,s,d and right b,s,d,e (window already shifted)
    always_comb
    begin
        if (sel_reg)
        begin
            op_o = win_reg[0];
            op_p = win_reg[1];
            op_q = win_reg[2];
            op_r = win_reg[3];
        end
        else
        begin
            op_o = a_reg;
            op_p = win_reg[0];
            op_q = win_reg[1];
            op_r = win_reg[2];
        end
    end

    assign sum_pq = NW'(op_p) + NW'(op_q);
    assign sum_or = NW'(op_o) + NW'(op_r);
    assign num    = (sum_pq <<< 3) - sum_pq - sum_or;
    assign n4     = num >>> 2;
    // floor(n/3) for negative n is ~floor(~n/3)
    assign mag_in = n4[NW-1] ? ~n4 : n4;

    assign digit  = div3_digit(rem_reg, mag_reg[MW-1 -: 4]);
    assign mag_nx = {mag_reg[MW-5:0], digit[5:2]};
    assign quot_s = neg_reg ? ~$signed({1'b0, mag_nx}) : $signed({1'b0, mag_nx});
    assign quot_f = FW'(quot_s);

    // centre cell and neighbours after the window shift
    assign b_f      = FW'(win_reg[0]);
    assign s_f      = FW'(win_reg[1]);
    assign d_f      = FW'(win_reg[2]);
    assign face_sum = (FW+1)'(lf_reg) + (FW+1)'(rf_reg);
    assign shift_v  = (FW+1)'(s_f) - (face_sum >>> 1);
    assign lo_l     = (b_f < s_f) ? b_f : s_f;
    assign hi_l     = (b_f < s_f) ? s_f : b_f;
    assign lo_r     = (d_f < s_f) ? d_f : s_f;
    assign hi_r     = (d_f < s_f) ? s_f : d_f;

    // limiter
    assign l_w      = LW'(lf_reg);
    assign r_w      = LW'(rf_reg);
    assign s_w      = LW'(s_f);
    assign tol_w    = LW'($signed({1'b0, tol_reg}));
    assign diff     = l_w + r_w - (s_w <<< 1);
    assign abs_diff = (diff < 0) ? -diff : diff;
    assign up       = diff > 0;
    assign dl       = l_w - s_w;
    assign dr       = r_w - s_w;
    assign cl       = up ? (dl > tol_w) : (dl < -tol_w);
    assign cr       = up ? (dr > tol_w) : (dr < -tol_w);
    assign adl      = (dl < 0) ? -dl : dl;
    assign adr      = (dr < 0) ? -dr : dr;
    assign step_l   = (corr_reg < adl) ? corr_reg : adl;
    assign step_r   = (corr_reg < adr) ? corr_reg : adr;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && fill_eff == FILL_FULL)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (dcnt_reg == DCNT_LAST)
                begin
                    state_next = sel_reg ? S_SHIFT : S_PREP;
                end
            end
            S_SHIFT:
            begin
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (pass_reg == lim_reg || !(cl || cr))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_MOVE;
                end
            end
            S_MOVE:
            begin
                state_next = S_EVAL;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_ready = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
            end
            S_DONE:
            begin
                load_out = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            lim_reg       <= LIMIT_RESET;
            tol_reg       <= TOL_RESET;
            dcnt_reg      <= '0;
            pass_reg      <= '0;
            sel_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                if (cfg_index == CFG_ITER_LIMIT)
                begin
                    lim_reg <= cfg_data[LIMIT_WIDTH-1:0];
                end
                if (cfg_index == CFG_TOLERANCE)
                begin
                    tol_reg <= cfg_data[TOL_WIDTH-1:0];
                end
            end
            if (accept)
            begin
                sel_reg <= 1'b0;
                if (fill_eff != FILL_FULL)
                begin
                    fill_reg <= fill_eff + 1'b1;
                end
                else
                begin
                    fill_reg <= fill_eff;
                end
            end
            if (state_reg == S_PREP)
            begin
                dcnt_reg <= '0;
            end
            if (state_reg == S_DIV)
            begin
                dcnt_reg <= dcnt_reg + 1'b1;
                if (dcnt_reg == DCNT_LAST)
                begin
                    sel_reg <= 1'b1;
                end
            end
            if (state_reg == S_CLAMP)
            begin
                pass_reg <= '0;
            end
            if (state_reg == S_MOVE)
            begin
                pass_reg <= pass_reg + 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (fill_eff == FILL_FULL)
            begin
                a_reg      <= win_reg[0];
                win_reg[0] <= win_reg[1];
                win_reg[1] <= win_reg[2];
                win_reg[2] <= win_reg[3];
                win_reg[3] <= e_val;
            end
            else
            begin
                win_reg[fill_eff[1:0]] <= e_val;
            end
        end
        case (state_reg)
            S_PREP:
            begin
                neg_reg <= n4[NW-1];
                mag_reg <= MW'(mag_in);
                rem_reg <= '0;
            end
            S_DIV:
            begin
                mag_reg <= mag_nx;
                rem_reg <= digit[1:0];
                if (dcnt_reg == DCNT_LAST)
                begin
                    if (sel_reg)
                    begin
                        rf_reg <= quot_f;
                    end
                    else
                    begin
                        lf_reg <= quot_f;
                    end
                end
            end
            S_SHIFT:
            begin
                lf_reg <= FW'((FW+1)'(lf_reg) + shift_v);
                rf_reg <= FW'((FW+1)'(rf_reg) + shift_v);
            end
            S_CLAMP:
            begin
                lf_reg <= (lf_reg < lo_l) ? lo_l : ((lf_reg > hi_l) ? hi_l : lf_reg);
                rf_reg <= (rf_reg < lo_r) ? lo_r : ((rf_reg > hi_r) ? hi_r : rf_reg);
            end
            S_EVAL:
            begin
                up_reg   <= up;
                cl_reg   <= cl;
                cr_reg   <= cr;
                corr_reg <= (cl && cr) ? (abs_diff >>> 1) : abs_diff;
            end
            S_MOVE:
            begin
                if (cl_reg)
                begin
                    lf_reg <= FW'(up_reg ? (l_w - step_l) : (l_w + step_l));
                end
                if (cr_reg)
                begin
                    rf_reg <= FW'(up_reg ? (r_w - step_r) : (r_w + step_r));
                end
            end
            default:
            begin
            end
        endcase
        if (load_out)
        begin
            left_out_reg  <= OUT_WIDTH'(OW'(lf_reg));
            right_out_reg <= OUT_WIDTH'(OW'(rf_reg));
        end
    end

    assign out_valid  = out_valid_reg;
    assign left_face  = left_out_reg;
    assign right_face = right_out_reg;

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_FULL)
        else $error("window fill count out of range");

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("input taken while a cell is in work");

    a_pass_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOVE) |-> (pass_reg < lim_reg))
        else $error("limiter ran past its pass limit");

    a_clamp_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL && pass_reg == '0) |->
            (lf_reg >= lo_l && lf_reg <= hi_l && rf_reg >= lo_r && rf_reg <= hi_r))
        else $error("clamped face outside its neighbour bounds");

endmodule
